// ===== sv/gfc_pkg.sv =====
// Shared types and codes for the GIF frame compositor.
`timescale 1ns / 1ps
package gfc_pkg;

  localparam int unsigned CANVAS_W = 256;
  localparam int unsigned CANVAS_H = 256;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_PIXEL = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_REJECTED = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DISP_NONE = 2'd0,
    DISP_KEEP = 2'd1,
    DISP_BG   = 2'd2,
    DISP_PREV = 2'd3
  } disp_e;

  localparam logic [1:0] CFG_BG = 2'd0;
  localparam logic [1:0] CFG_W  = 2'd1;
  localparam logic [1:0] CFG_H  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] frame_left;
    logic [7:0] frame_top;
    logic [8:0] frame_width;
    logic [8:0] frame_height;
    logic       interlaced;
    logic       has_transparent;
    logic [7:0] transparent_index;
    logic [1:0] disposal_mode;
    logic [7:0] pixel_index;
    logic [7:0] read_x;
    logic [7:0] read_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic [1:0] status;
    logic       frame_done;
  } out_item_t;

  // Command from front to back end.
  typedef struct packed {
    logic [2:0] op;        // see OP_* codes
    logic [7:0] x;
    logic [7:0] y;
    logic [8:0] w;
    logic [8:0] h;
    logic [7:0] data;
    logic       done;
    logic       bgfill;    // frame start: apply background disposal first
    logic       restore;   // frame start: restore backup first
    logic       backup;    // frame start: back up canvas afterwards
    logic [1:0] status;
  } cmd_t;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_FRAME = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam int unsigned QDEPTH = 4;

endpackage

// ===== sv/gif_frame_compositor.sv =====
// GIF frame compositor top level.
// Usage:
//   in_valid_i/in_ready_o carry one item (clear, frame start, pixel or read) per
//   transfer; out_valid_o/out_ready_i return exactly one result per item, in order.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Flow:
//   The front end tracks the frame cursor and classifies each item in the cycle of
//   its transfer into a four-entry command queue. Pixels and dropped items sustain
//   one per cycle while the receiver takes results.
//   A clear holds the back end while it fills the whole canvas; a frame start
//   holds it while it fills the clipped rectangle for background disposal, then
//   while it copies the whole canvas for a restore and again for a backup.
// Reset:
//   Registers return to defaults (256x256 canvas, background 0), no frame active.
//   Canvas content is undefined until the first clear; no clearing pass is run.
// Stall:
//   A stalled receiver holds the result register; the queue absorbs up to four
//   more items, after which in_ready_o drops.
`timescale 1ns / 1ps
module gif_frame_compositor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gfc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gfc_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [8:0]         cfg_data_i
);
  import gfc_pkg::*;

  logic [7:0] bg_q;
  logic [8:0] cw_q, ch_q, eff_w, eff_h;
  logic       q_ready, q_valid, q_pop, f_valid;
  cmd_t       f_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q <= '0; cw_q <= 9'd256; ch_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BG: bg_q <= cfg_data_i[7:0];
        CFG_W:  cw_q <= cfg_data_i;
        CFG_H:  ch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (cw_q == '0) ? 9'd1 : ({23'b0, cw_q} > CANVAS_W) ? 9'(CANVAS_W) : cw_q;
  assign eff_h = (ch_q == '0) ? 9'd1 : ({23'b0, ch_q} > CANVAS_H) ? 9'(CANVAS_H) : ch_q;

  gfc_front u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o), .item_i(in_data_i),
    .eff_w_i(eff_w), .eff_h_i(eff_h), .bg_i(bg_q),
    .cmd_valid_o(f_valid), .cmd_ready_i(q_ready), .cmd_o(f_cmd)
  );

  gfc_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .ready_o(q_ready), .data_i(f_cmd),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_cmd)
  );

  gfc_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_pop_o(q_pop), .cmd_i(q_cmd),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .item_o(out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != ST_RSVD)
    else $error("illegal status");
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done |-> out_data_o.status == ST_OK)
    else $error("frame done with error status");
`endif
endmodule

// ===== sv/gfc_front.sv =====
// Front end: frame and cursor tracking, classification of items into commands.
`timescale 1ns / 1ps
module gfc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gfc_pkg::in_item_t  item_i,
  input  logic [8:0]         eff_w_i,
  input  logic [8:0]         eff_h_i,
  input  logic [7:0]         bg_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output gfc_pkg::cmd_t      cmd_o
);
  import gfc_pkg::*;

  logic [1:0] pend_disp_q, pend_disp_d;
  logic [7:0] pl_q, pl_d, pt_q, pt_d;
  logic [8:0] pw_q, pw_d, ph_q, ph_d;
  logic [7:0] al_q, al_d, at_q, at_d, atr_q, atr_d;
  logic [8:0] aw_q, aw_d, ah_q, ah_d;
  logic       ail_q, ail_d, aht_q, aht_d;
  logic [1:0] pass_q, pass_d;
  logic [8:0] row_q, row_d, col_q, col_d;
  logic       act_q, act_d, seen_q, seen_d;
  cmd_t       c;
  logic       acc;
  logic [9:0] xe, ye, nrow;
  logic [8:0] ncol;
  logic [3:0] step;

  assign ready_o = cmd_ready_i;
  assign cmd_valid_o = valid_i;
  assign acc = valid_i && cmd_ready_i;
  assign cmd_o = c;

  always_comb begin
    pend_disp_d = pend_disp_q; pl_d = pl_q; pt_d = pt_q; pw_d = pw_q; ph_d = ph_q;
    al_d = al_q; at_d = at_q; aw_d = aw_q; ah_d = ah_q; ail_d = ail_q;
    aht_d = aht_q; atr_d = atr_q; pass_d = pass_q; row_d = row_q; col_d = col_q;
    act_d = act_q; seen_d = seen_q;
    c = '0;
    c.op = OP_NONE;
    c.status = ST_OK;
    xe = {2'b0, item_i.frame_left} + {1'b0, item_i.frame_width};
    ye = {2'b0, item_i.frame_top} + {1'b0, item_i.frame_height};
    ncol = col_q + 9'd1;
    unique case (pass_q)
      2'd0, 2'd1: step = 4'd8;
      2'd2: step = 4'd4;
      default: step = 4'd2;
    endcase
    nrow = {1'b0, row_q} + (ail_q ? {6'b0, step} : 10'd1);
    unique case (func_e'(item_i.func))
      FUNC_CLEAR: begin
        c.op = OP_CLEAR;
        c.data = bg_i;
        c.w = 9'(CANVAS_W);
        c.h = 9'(CANVAS_H);
      end
      FUNC_FRAME: begin
        if (item_i.frame_width == '0 || item_i.frame_height == '0 ||
            xe > {1'b0, eff_w_i} || ye > {1'b0, eff_h_i}) begin
          c.status = ST_REJECTED;
          act_d = 1'b0;
        end else begin
          c.op = OP_FRAME;
          c.bgfill = seen_q && pend_disp_q == DISP_BG;
          c.restore = seen_q && pend_disp_q == DISP_PREV;
          c.backup = item_i.disposal_mode == DISP_PREV;
          c.x = pl_q; c.y = pt_q; c.data = bg_i;
          // clip stale rectangle to canvas
          c.w = ({2'b0, pl_q} + {1'b0, pw_q} > {1'b0, eff_w_i}) ?
                9'(eff_w_i - {1'b0, pl_q}) : pw_q;
          c.h = ({2'b0, pt_q} + {1'b0, ph_q} > {1'b0, eff_h_i}) ?
                9'(eff_h_i - {1'b0, pt_q}) : ph_q;
          if ({1'b0, pl_q} >= eff_w_i || {1'b0, pt_q} >= eff_h_i) c.bgfill = 1'b0;
          al_d = item_i.frame_left; at_d = item_i.frame_top;
          aw_d = item_i.frame_width; ah_d = item_i.frame_height;
          ail_d = item_i.interlaced; aht_d = item_i.has_transparent;
          atr_d = item_i.transparent_index;
          pass_d = '0; row_d = '0; col_d = '0;
          act_d = 1'b1; seen_d = 1'b1;
          pend_disp_d = item_i.disposal_mode;
          pl_d = item_i.frame_left; pt_d = item_i.frame_top;
          pw_d = item_i.frame_width; ph_d = item_i.frame_height;
        end
      end
      FUNC_PIXEL: begin
        if (!act_q) begin
          c.status = ST_DROPPED;
        end else begin
          // rectangle was validated, so position is always on the store
          if (!(aht_q && item_i.pixel_index == atr_q)) c.op = OP_WRITE;
          c.x = 8'(al_q + col_q[7:0]);
          c.y = 8'(at_q + row_q[7:0]);
          c.data = item_i.pixel_index;
          col_d = ncol;
          if (ncol >= aw_q) begin
            col_d = '0;
            if (!ail_q) begin
              row_d = nrow[8:0];
              if (nrow >= {1'b0, ah_q}) begin act_d = 1'b0; c.done = 1'b1; end
            end else if (nrow < {1'b0, ah_q}) begin
              row_d = nrow[8:0];
            end else begin
              // walk forward through passes whose start row fits
              priority if (pass_q == 2'd0 && ah_q > 9'd4) begin
                pass_d = 2'd1; row_d = 9'd4;
              end else if (pass_q <= 2'd1 && ah_q > 9'd2) begin
                pass_d = 2'd2; row_d = 9'd2;
              end else if (pass_q <= 2'd2 && ah_q > 9'd1) begin
                pass_d = 2'd3; row_d = 9'd1;
              end else begin
                act_d = 1'b0; c.done = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        c.op = OP_READ;
        c.x = item_i.read_x; c.y = item_i.read_y;
        if ({1'b0, item_i.read_x} >= eff_w_i || {1'b0, item_i.read_y} >= eff_h_i)
          c.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_disp_q <= '0; pl_q <= '0; pt_q <= '0; pw_q <= '0; ph_q <= '0;
      al_q <= '0; at_q <= '0; aw_q <= '0; ah_q <= '0; ail_q <= 1'b0;
      aht_q <= 1'b0; atr_q <= '0; pass_q <= '0; row_q <= '0; col_q <= '0;
      act_q <= 1'b0; seen_q <= 1'b0;
    end else if (acc) begin
      pend_disp_q <= pend_disp_d; pl_q <= pl_d; pt_q <= pt_d; pw_q <= pw_d;
      ph_q <= ph_d; al_q <= al_d; at_q <= at_d; aw_q <= aw_d; ah_q <= ah_d;
      ail_q <= ail_d; aht_q <= aht_d; atr_q <= atr_d; pass_q <= pass_d;
      row_q <= row_d; col_q <= col_d; act_q <= act_d; seen_q <= seen_d;
    end
  end
endmodule

// ===== sv/gfc_queue.sv =====
// Small FIFO between front and back end.
`timescale 1ns / 1ps
module gfc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           ready_o,
  input  gfc_pkg::cmd_t  data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output gfc_pkg::cmd_t  data_o
);
  import gfc_pkg::*;

  localparam int unsigned AW = $clog2(QDEPTH);
  cmd_t          mem_q [QDEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign ready_o = cnt_q != AW'(0) + (AW+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && ready_o) wp_q <= wp_q + AW'(1);
      if (pop_i && valid_o) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i && ready_o) - (AW+1)'(pop_i && valid_o);
    end
  end
endmodule

// ===== sv/gfc_back.sv =====
// Back end: canvas and backup memories, fill/copy sequencer and result register.
`timescale 1ns / 1ps
module gfc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  gfc_pkg::cmd_t      cmd_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gfc_pkg::out_item_t item_o
);
  import gfc_pkg::*;

  localparam int unsigned XW = $clog2(CANVAS_W);
  localparam int unsigned YW = $clog2(CANVAS_H);
  localparam int unsigned AW = XW + YW;
  localparam int unsigned DEPTH = CANVAS_W * CANVAS_H;

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_RESTORE, S_BACKUP, S_OUT
  } state_e;

  logic [7:0]    canvas_mem [DEPTH];
  logic [7:0]    backup_mem [DEPTH];
  state_e        state_q;
  cmd_t          cur_q;
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic [AW:0]   ca_q;
  logic [7:0]    rd_q, bk_q, cv_q;
  logic          bvalid_q;
  logic [AW-1:0] bkaddr_q;
  out_item_t     res_q;
  logic          ovalid_q;
  logic          slot_free;
  logic          emit;
  logic [XW-1:0] fx_end;
  logic [YW-1:0] fy_end;

  assign slot_free = !ovalid_q || ready_i;
  assign valid_o = ovalid_q;
  assign item_o = res_q;
  assign cmd_pop_o = state_q == S_IDLE && cmd_valid_i &&
                     (slot_free || cmd_i.op == OP_CLEAR || cmd_i.op == OP_FRAME ||
                      cmd_i.op == OP_READ) && !(cmd_i.op == OP_NONE && !slot_free)
                     && !((cmd_i.op == OP_WRITE) && !slot_free);
  assign emit = (cmd_pop_o && cmd_i.op != OP_CLEAR && cmd_i.op != OP_FRAME &&
                 cmd_i.op != OP_READ) || (state_q == S_OUT && slot_free);
  assign fx_end = XW'(cur_q.x + cur_q.w[7:0] - 8'd1);
  assign fy_end = YW'(cur_q.y + cur_q.h[7:0] - 8'd1);

  // memories
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_pop_o && cmd_i.op == OP_WRITE)
      canvas_mem[{YW'(cmd_i.y), XW'(cmd_i.x)}] <= cmd_i.data;
    else if (state_q == S_FILL)
      canvas_mem[{cy_q, cx_q}] <= cur_q.data;
    else if (state_q == S_RESTORE && bvalid_q)
      canvas_mem[bkaddr_q] <= bk_q;
    if (state_q == S_BACKUP && bvalid_q)
      backup_mem[bkaddr_q] <= cv_q;
    if (state_q == S_IDLE)
      rd_q <= canvas_mem[{YW'(cmd_i.y), XW'(cmd_i.x)}];
    bk_q <= backup_mem[ca_q[AW-1:0]];
    cv_q <= canvas_mem[ca_q[AW-1:0]];
    bkaddr_q <= ca_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
      bvalid_q <= 1'b0;
      cur_q <= '0; cx_q <= '0; cy_q <= '0; ca_q <= '0; res_q <= '0;
    end else begin
      if (emit) ovalid_q <= 1'b1;
      else if (ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_pop_o) begin
          cur_q <= cmd_i;
          cx_q <= XW'(cmd_i.x); cy_q <= YW'(cmd_i.y);
          unique case (cmd_i.op)
            OP_CLEAR: state_q <= S_FILL;
            OP_FRAME: begin
              ca_q <= '0; bvalid_q <= 1'b0;
              priority if (cmd_i.bgfill) state_q <= S_FILL;
              else if (cmd_i.restore) state_q <= S_RESTORE;
              else if (cmd_i.backup) state_q <= S_BACKUP;
              else state_q <= S_OUT;
            end
            OP_READ: state_q <= S_OUT;
            default: res_q <= '{pixel_value: 8'd0, status: cmd_i.status,
                                frame_done: cmd_i.done};
          endcase
        end
        S_FILL: begin
          if (cx_q == fx_end) begin
            cx_q <= XW'(cur_q.x);
            cy_q <= cy_q + YW'(1);
            if (cy_q == fy_end) begin
              ca_q <= '0;
              state_q <= (cur_q.op == OP_FRAME && cur_q.backup) ? S_BACKUP : S_OUT;
            end
          end else cx_q <= cx_q + XW'(1);
        end
        S_RESTORE: begin
          bvalid_q <= !ca_q[AW];
          if (!ca_q[AW]) ca_q <= ca_q + (AW+1)'(1);
          else begin
            ca_q <= '0;
            state_q <= cur_q.backup ? S_BACKUP : S_OUT;
          end
        end
        S_BACKUP: begin
          bvalid_q <= !ca_q[AW];
          if (!ca_q[AW]) ca_q <= ca_q + (AW+1)'(1);
          else begin
            ca_q <= '0;
            state_q <= S_OUT;
          end
        end
        default: if (slot_free) begin
          res_q <= '{pixel_value: (cur_q.op == OP_READ) ? rd_q : 8'd0,
                     status: cur_q.status, frame_done: cur_q.done};
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule
